// ===== rtl/mck_pkg.sv =====
// Package for the Morse character keyer: phase codes, register indexes and code table.
package mck_pkg;

  localparam int UnitW = 16;
  localparam int GapW  = 3;
  localparam int PatW  = 5;
  localparam int CntW  = 3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  localparam logic [1:0] REG_UNIT_TICKS = 2'd0;
  localparam logic [1:0] REG_GAP_UNITS  = 2'd1;
  localparam logic [1:0] REG_ACT_LOW    = 2'd2;

  localparam logic [UnitW-1:0] UNIT_TICKS_RST = 16'd400;
  localparam logic [GapW-1:0]  GAP_UNITS_RST  = 3'd3;

  // elements after the first, and element pattern (bit 0 first, 1 = dash)
  typedef struct packed {
    logic [CntW-1:0] rest;
    logic [PatW-1:0] bits;
  } morse_t;

  typedef struct packed {
    logic   valid;
    morse_t code;
  } lookup_t;

  localparam morse_t LETTERS [26] = '{
    '{3'd1, 5'b00010}, '{3'd3, 5'b00001}, '{3'd3, 5'b00101}, '{3'd2, 5'b00001},
    '{3'd0, 5'b00000}, '{3'd3, 5'b00100}, '{3'd2, 5'b00011}, '{3'd3, 5'b00000},
    '{3'd1, 5'b00000}, '{3'd3, 5'b01110}, '{3'd2, 5'b00101}, '{3'd3, 5'b00010},
    '{3'd1, 5'b00011}, '{3'd1, 5'b00001}, '{3'd2, 5'b00111}, '{3'd3, 5'b00110},
    '{3'd3, 5'b01011}, '{3'd2, 5'b00010}, '{3'd2, 5'b00000}, '{3'd0, 5'b00001},
    '{3'd2, 5'b00100}, '{3'd3, 5'b01000}, '{3'd2, 5'b00110}, '{3'd3, 5'b01001},
    '{3'd3, 5'b01101}, '{3'd3, 5'b00011}
  };

  localparam morse_t DIGITS [10] = '{
    '{3'd4, 5'b11111}, '{3'd4, 5'b11110}, '{3'd4, 5'b11100}, '{3'd4, 5'b11000},
    '{3'd4, 5'b10000}, '{3'd4, 5'b00000}, '{3'd4, 5'b00001}, '{3'd4, 5'b00011},
    '{3'd4, 5'b00111}, '{3'd4, 5'b01111}
  };

  function automatic lookup_t morse_lookup(input logic [7:0] c);
    lookup_t r;
    logic [7:0] off;
    r = '0;
    off = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      off = c - 8'h41;
      r.valid = 1'b1;
      r.code = LETTERS[off[4:0]];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      off = c - 8'h30;
      r.valid = 1'b1;
      r.code = DIGITS[off[3:0]];
    end
    return r;
  endfunction

endpackage

// ===== rtl/morse_character_keyer.sv =====
// Morse character keyer: table lookup, unit timing and lamp drive in one pass per word.
//
// Input stream: s_axis_tuser = 0 is a time tick, 1 sends the character in
// s_axis_tdata (ASCII A-Z or 0-9). Every input word gives one result word on
// the m_axis side, held in an output register: lamp pin level, busy flag,
// character-done flag and rejected flag.
// The result is registered and valid in the cycle after acceptance; one word
// per cycle is sustained while the receiver takes each result.
// While the receiver stalls with a result pending, s_axis_tready drops; it
// rises again in the cycle the pending result is taken, so a new word can be
// accepted at the same edge the old result leaves.
// Configuration words (index 0 unit_ticks, 1 letter_gap_units, 2
// lamp_active_low) are taken every cycle on the cfg channel; other indexes
// are ignored. A send while a character is in progress, or of a code outside
// the table, is refused with rejected set.
// Synchronous reset (rst high) returns to idle with unit_ticks 400, a three
// unit letter gap, active-low lamp and no result pending.
module morse_character_keyer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // pin_level, busy_res, char_done, rejected, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mck_pkg::*;

  logic [UnitW-1:0] unit_ticks;
  logic [GapW-1:0]  gap_units;
  logic             act_low;

  logic [PatW-1:0]  pattern_bits, pattern_bits_next;
  logic [CntW-1:0]  elements_left, elements_left_next;
  logic [1:0]       phase, phase_next;
  logic [UnitW-1:0] tick_count, tick_count_next;
  logic [CntW-1:0]  units_left, units_left_next;

  logic             accept;
  logic             done, rej;
  logic [UnitW-1:0] limit;
  logic [UnitW-1:0] tick_inc;
  logic [CntW-1:0]  units_dec;
  lookup_t          lk;
  logic [3:0]       res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign limit     = (unit_ticks == '0) ? UnitW'(1) : unit_ticks;
  assign tick_inc  = tick_count + UnitW'(1);
  assign units_dec = units_left - CntW'(1);
  assign lk        = morse_lookup(s_axis_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RST;
      gap_units  <= GAP_UNITS_RST;
      act_low    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UNIT_TICKS: unit_ticks <= cfg_data;
        REG_GAP_UNITS:  gap_units  <= cfg_data[GapW-1:0];
        REG_ACT_LOW:    act_low    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pattern_bits_next  = pattern_bits;
    elements_left_next = elements_left;
    phase_next         = phase;
    tick_count_next    = tick_count;
    units_left_next    = units_left;
    done = 1'b0;
    rej  = 1'b0;
    if (s_axis_tuser) begin
      if (phase != PH_IDLE || !lk.valid) begin
        rej = 1'b1;
      end else begin
        // load and start the first element at once
        units_left_next    = lk.code.bits[0] ? CntW'(3) : CntW'(1);
        pattern_bits_next  = lk.code.bits >> 1;
        elements_left_next = lk.code.rest;
        phase_next         = PH_ON;
        tick_count_next    = '0;
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        tick_count_next = '0;
        units_left_next = units_dec;
        if (units_dec == '0) begin
          unique case (phase)
            PH_ON: begin
              phase_next      = PH_OFF;
              units_left_next = CntW'(1);
            end
            PH_OFF: begin
              if (elements_left != '0) begin
                elements_left_next = elements_left - CntW'(1);
                units_left_next    = pattern_bits[0] ? CntW'(3) : CntW'(1);
                pattern_bits_next  = pattern_bits >> 1;
                phase_next         = PH_ON;
              end else if (gap_units != '0) begin
                phase_next      = PH_GAP;
                units_left_next = gap_units;
              end else begin
                phase_next         = PH_IDLE;
                pattern_bits_next  = '0;
                elements_left_next = '0;
                done               = 1'b1;
              end
            end
            default: begin
              phase_next         = PH_IDLE;
              pattern_bits_next  = '0;
              elements_left_next = '0;
              done               = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // result fields, lowest bit first
  assign res = {rej, done, (phase_next != PH_IDLE), (phase_next == PH_ON) ^ act_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits  <= '0;
      elements_left <= '0;
      phase         <= PH_IDLE;
      tick_count    <= '0;
      units_left    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        pattern_bits  <= pattern_bits_next;
        elements_left <= elements_left_next;
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        units_left    <= units_left_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {4'b0000, res};
    end
  end

endmodule
